[hw/rtl/lpb_pkg.sv]
package lpb_pkg;

    localparam int REQ_W  = 2;
    localparam int TAB_W  = 10;
    localparam int PAGE_W = 32;
    localparam int PIN_W  = 8;
    localparam int STAT_W = 3;
    localparam int FIDX_W = 6;
    localparam int CFG_W  = 7;

    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNPIN = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FILL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_REPLACE = 3'd2;
    localparam logic [STAT_W-1:0] ST_PINNED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd4;

    localparam logic [PIN_W-1:0] PIN_MAX   = 8'd255;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Per-entry outcome of the shared compare unit.
    typedef struct packed {
        logic hit;
        logic vic_better;
        logic fill_match;
    } scan_flags_t;

endpackage

[hw/rtl/lpb_frame_ram.sv]
module lpb_frame_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/lpb_entry_unit.sv]
module lpb_entry_unit #(
    parameter int NUM_FRAMES = 64
) (
    input  logic [$clog2(NUM_FRAMES)-1:0] idx,
    input  logic [lpb_pkg::TAB_W-1:0]     e_table,
    input  logic [lpb_pkg::PAGE_W-1:0]    e_page,
    input  logic [lpb_pkg::PIN_W-1:0]     e_pin,
    input  logic [$clog2(NUM_FRAMES)-1:0] e_rank,
    input  logic                          rank_live,
    input  logic [lpb_pkg::TAB_W-1:0]     tab,
    input  logic [lpb_pkg::PAGE_W-1:0]    pg,
    input  logic [$clog2(NUM_FRAMES):0]   filled,
    input  logic                          vic_found,
    input  logic [$clog2(NUM_FRAMES)-1:0] vic_rank,
    input  logic [$clog2(NUM_FRAMES)-1:0] tgt_rank,
    output logic [$clog2(NUM_FRAMES)-1:0] rank_eff,
    output logic [$clog2(NUM_FRAMES)-1:0] rank_upd,
    output lpb_pkg::scan_flags_t          flags
);

    import lpb_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);

    logic entry_valid;

    // Frames are filled in index order and never freed, so the fill count
    // tells which frames hold a page.
    assign entry_valid = {1'b0, idx} < filled;

    // Until the first recency pass has rewritten every entry, the stored
    // rank is not yet meaningful and the reset order applies.
    assign rank_eff = rank_live ? e_rank : idx;

    assign flags.hit        = entry_valid && (e_table == tab) && (e_page == pg);
    assign flags.vic_better = entry_valid && (e_pin == '0)
                              && (!vic_found || (rank_eff > vic_rank));
    assign flags.fill_match = ({1'b0, idx} == filled);

    assign rank_upd = (rank_eff < tgt_rank) ? FW'(rank_eff + 1'b1) : rank_eff;

endmodule

[hw/rtl/lru_page_buffer_with_pinning_unit.sv]
// LRU page buffer with pin counts. Each request names a page by table and page
// number; the block reports whether it hit, took a free frame or replaced the
// least recently used unpinned frame (with a write-back flag if that frame was
// dirty), and returns the frame's pin count afterwards. Frame tags, pin counts,
// dirty marks and recency ranks live in one single-port-read, single-port-write
// memory, and one compare unit walks it. A request makes one pass over all frames
// for lookup and victim search, and read and write requests that get a frame then
// make a second pass that rewrites the recency ranks; unpin requests and misses
// with no usable frame skip the second pass. The block takes one request at a
// time, and a new request can be accepted while the previous result still waits
// on the output. No clearing pass is needed after reset. The frame limit register
// is written through its own port; the user must write it only while the block is
// idle, which the block itself does not enforce. A value of 0 acts as 1 and values
// above NUM_FRAMES act as NUM_FRAMES.
module lru_page_buffer_with_pinning_unit #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lpb_pkg::CFG_W-1:0]   cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lpb_pkg::REQ_W-1:0]   req_type,
    input  logic [lpb_pkg::TAB_W-1:0]   table_num,
    input  logic [lpb_pkg::PAGE_W-1:0]  page_number,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lpb_pkg::STAT_W-1:0]  status,
    output logic [lpb_pkg::FIDX_W-1:0]  frame_index,
    output logic                        fetch_needed,
    output logic                        writeback_needed,
    output logic [lpb_pkg::TAB_W-1:0]   victim_table,
    output logic [lpb_pkg::PAGE_W-1:0]  victim_page,
    output logic [lpb_pkg::PIN_W-1:0]   pin_after
);

    import lpb_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = (FW + 1 > CFG_W) ? FW + 1 : CFG_W;
    localparam int EW = TAB_W + PAGE_W + PIN_W + 1 + FW;
    localparam logic [FW:0]   CNT_END = (FW + 1)'(NUM_FRAMES);
    localparam logic [CW-1:0] LIM_MAX = CW'(NUM_FRAMES);
    localparam logic [CW-1:0] LIM_MIN = CW'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [FW-1:0]     hit_idx;
        logic [PIN_W-1:0]  hit_pin;
        logic              hit_dirty;
        logic [FW-1:0]     hit_rank;
        logic              vic_found;
        logic [FW-1:0]     vic_idx;
        logic [FW-1:0]     vic_rank;
        logic              vic_dirty;
        logic [TAB_W-1:0]  vic_tab;
        logic [PAGE_W-1:0] vic_page;
        logic [FW-1:0]     fill_rank;
    } scan_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FW-1:0]     frame;
        logic              fetch;
        logic              wb;
        logic [TAB_W-1:0]  vtab;
        logic [PAGE_W-1:0] vpage;
        logic [PIN_W-1:0]  pin;
    } result_t;

    typedef struct packed {
        logic [FW-1:0]    idx;
        logic [FW-1:0]    rank;
        logic [PIN_W-1:0] pin;
        logic             dirty;
    } target_t;

    state_t             state_reg, state_next;
    logic [FW:0]        cnt_reg, cnt_next;
    logic               pv_reg, pv_next;
    logic [FW-1:0]      pidx_reg, pidx_next;
    logic [FW:0]        filled_reg, filled_next;
    logic               rank_live_reg, rank_live_next;
    logic [CFG_W-1:0]   limit_cfg_reg, limit_cfg_next;
    logic               out_valid_reg, out_valid_next;

    logic [REQ_W-1:0]   type_reg, type_next;
    logic [TAB_W-1:0]   tab_reg, tab_next;
    logic [PAGE_W-1:0]  pg_reg, pg_next;
    scan_t              sc_reg, sc_next;
    target_t            tgt_reg, tgt_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;

    logic               ram_we;
    logic [FW-1:0]      ram_waddr;
    logic [EW-1:0]      ram_wdata;
    logic               ram_re;
    logic [EW-1:0]      ram_rdata;

    logic [TAB_W-1:0]   e_table;
    logic [PAGE_W-1:0]  e_page;
    logic [PIN_W-1:0]   e_pin;
    logic               e_dirty;
    logic [FW-1:0]      e_rank;
    logic [FW-1:0]      rank_eff;
    logic [FW-1:0]      rank_upd;
    scan_flags_t        flags;

    logic [CW-1:0]      limit;
    logic [CW-1:0]      limit_raw;
    logic               have_frame;
    logic [FW-1:0]      f_idx;
    logic [FW-1:0]      f_rank;
    logic [PIN_W-1:0]   old_pin;
    logic               old_dirty;
    logic [PIN_W-1:0]   new_pin;
    logic [PIN_W-1:0]   unpin_pin;

    assign {e_table, e_page, e_pin, e_dirty, e_rank} = ram_rdata;

    lpb_frame_ram #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (cnt_reg[FW-1:0]),
        .rd_data (ram_rdata)
    );

    lpb_entry_unit #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_entry (
        .idx       (pidx_reg),
        .e_table   (e_table),
        .e_page    (e_page),
        .e_pin     (e_pin),
        .e_rank    (e_rank),
        .rank_live (rank_live_reg),
        .tab       (tab_reg),
        .pg        (pg_reg),
        .filled    (filled_reg),
        .vic_found (sc_reg.vic_found),
        .vic_rank  (sc_reg.vic_rank),
        .tgt_rank  (tgt_reg.rank),
        .rank_eff  (rank_eff),
        .rank_upd  (rank_upd),
        .flags     (flags)
    );

    // Effective frame limit, clamped to one through the number of frames.
    assign limit_raw = CW'(limit_cfg_reg);
    assign limit = (limit_raw < LIM_MIN) ? LIM_MIN :
                   (limit_raw > LIM_MAX) ? LIM_MAX : limit_raw;

    assign unpin_pin = (sc_reg.hit_pin == '0) ? '0 : sc_reg.hit_pin - 1'b1;

    // Pick the frame a read or write request lands in.
    always_comb
    begin
        have_frame = 1'b1;
        f_idx      = sc_reg.hit_idx;
        f_rank     = sc_reg.hit_rank;
        old_pin    = sc_reg.hit_pin;
        old_dirty  = sc_reg.hit_dirty;
        if (!sc_reg.hit)
        begin
            old_pin   = '0;
            old_dirty = 1'b0;
            if (CW'(filled_reg) < limit)
            begin
                f_idx  = filled_reg[FW-1:0];
                f_rank = sc_reg.fill_rank;
            end
            else if (sc_reg.vic_found)
            begin
                f_idx  = sc_reg.vic_idx;
                f_rank = sc_reg.vic_rank;
            end
            else
            begin
                have_frame = 1'b0;
            end
        end
        if (type_reg == REQ_READ)
        begin
            new_pin = (old_pin == PIN_MAX) ? old_pin : old_pin + 1'b1;
        end
        else
        begin
            new_pin = (old_pin == '0) ? old_pin : old_pin - 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        filled_next    = filled_reg;
        rank_live_next = rank_live_reg;
        limit_cfg_next = limit_cfg_reg;
        out_valid_next = out_valid_reg;
        type_next      = type_reg;
        tab_next       = tab_reg;
        pg_next        = pg_reg;
        sc_next        = sc_reg;
        tgt_next       = tgt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = pidx_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;

        if (cfg_valid)
        begin
            limit_cfg_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                pv_next = 1'b0;
                cnt_next = '0;
                if (in_valid)
                begin
                    type_next = req_type;
                    tab_next  = table_num;
                    pg_next   = page_number;
                    sc_next.hit       = 1'b0;
                    sc_next.vic_found = 1'b0;
                    if (req_type != REQ_NONE)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                ram_re    = cnt_reg < CNT_END;
                pv_next   = cnt_reg < CNT_END;
                pidx_next = cnt_reg[FW-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (pv_reg)
                begin
                    if (flags.hit)
                    begin
                        sc_next.hit       = 1'b1;
                        sc_next.hit_idx   = pidx_reg;
                        sc_next.hit_pin   = e_pin;
                        sc_next.hit_dirty = e_dirty;
                        sc_next.hit_rank  = rank_eff;
                    end
                    if (flags.vic_better)
                    begin
                        sc_next.vic_found = 1'b1;
                        sc_next.vic_idx   = pidx_reg;
                        sc_next.vic_rank  = rank_eff;
                        sc_next.vic_dirty = e_dirty;
                        sc_next.vic_tab   = e_table;
                        sc_next.vic_page  = e_page;
                    end
                    if (flags.fill_match)
                    begin
                        sc_next.fill_rank = rank_eff;
                    end
                end
                if (cnt_reg == CNT_END)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                res_next   = '0;
                cnt_next   = '0;
                pv_next    = 1'b0;
                state_next = S_FINISH;
                if (type_reg == REQ_UNPIN)
                begin
                    if (sc_reg.hit)
                    begin
                        // Unpin leaves the recency order alone: one write only.
                        ram_we    = 1'b1;
                        ram_waddr = sc_reg.hit_idx;
                        ram_wdata = {tab_reg, pg_reg, unpin_pin, sc_reg.hit_dirty,
                                     sc_reg.hit_rank};
                        res_next.status = ST_HIT;
                        res_next.frame  = sc_reg.hit_idx;
                        res_next.pin    = unpin_pin;
                    end
                    else
                    begin
                        res_next.status = ST_ABSENT;
                    end
                end
                else if (!have_frame)
                begin
                    res_next.status = ST_PINNED;
                end
                else
                begin
                    state_next     = S_UPDATE;
                    tgt_next.idx   = f_idx;
                    tgt_next.rank  = f_rank;
                    tgt_next.pin   = new_pin;
                    tgt_next.dirty = old_dirty || (type_reg == REQ_WRITE);
                    res_next.frame = f_idx;
                    res_next.pin   = new_pin;
                    if (sc_reg.hit)
                    begin
                        res_next.status = ST_HIT;
                    end
                    else if (CW'(filled_reg) < limit)
                    begin
                        res_next.status = ST_FILL;
                        res_next.fetch  = 1'b1;
                        filled_next     = filled_reg + 1'b1;
                    end
                    else
                    begin
                        res_next.status = ST_REPLACE;
                        res_next.fetch  = 1'b1;
                        res_next.wb     = sc_reg.vic_dirty;
                        res_next.vtab   = sc_reg.vic_tab;
                        res_next.vpage  = sc_reg.vic_page;
                    end
                end
            end

            S_UPDATE:
            begin
                ram_re    = cnt_reg < CNT_END;
                pv_next   = cnt_reg < CNT_END;
                pidx_next = cnt_reg[FW-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (pv_reg)
                begin
                    ram_we = 1'b1;
                    if (pidx_reg == tgt_reg.idx)
                    begin
                        ram_wdata = {tab_reg, pg_reg, tgt_reg.pin, tgt_reg.dirty, FW'(0)};
                    end
                    else
                    begin
                        ram_wdata = {e_table, e_page, e_pin, e_dirty, rank_upd};
                    end
                end
                if (cnt_reg == CNT_END)
                begin
                    rank_live_next = 1'b1;
                    state_next     = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            filled_reg    <= '0;
            rank_live_reg <= 1'b0;
            limit_cfg_reg <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            filled_reg    <= filled_next;
            rank_live_reg <= rank_live_next;
            limit_cfg_reg <= limit_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        type_reg <= type_next;
        tab_reg  <= tab_next;
        pg_reg   <= pg_next;
        sc_reg   <= sc_next;
        tgt_reg  <= tgt_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign cfg_ready        = 1'b1;
    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = out_reg.status;
    assign frame_index      = FIDX_W'(out_reg.frame);
    assign fetch_needed     = out_reg.fetch;
    assign writeback_needed = out_reg.wb;
    assign victim_table     = out_reg.vtab;
    assign victim_page      = out_reg.vpage;
    assign pin_after        = out_reg.pin;

endmodule

[bench/testbench.sv]
module testbench;
    import lpb_pkg::*;

    localparam int NUM_FRAMES = 64;
    // One full lookup pass plus the recency rewrite pass, with some margin.
    localparam int DRAIN_CYCLES = 2 * NUM_FRAMES + 20;
    localparam int MAX_CYCLES = 1_500_000;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [TAB_W-1:0]  tab;
        logic [PAGE_W-1:0] page;
    } page_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FIDX_W-1:0] frame;
        logic              fetch;
        logic              wb;
        logic [TAB_W-1:0]  vtab;
        logic [PAGE_W-1:0] vpage;
        logic [PIN_W-1:0]  pin;
    } page_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type;
    logic [TAB_W-1:0]    table_num;
    logic [PAGE_W-1:0]   page_number;
    logic                out_valid;
    logic                out_ready;
    logic [STAT_W-1:0]   status;
    logic [FIDX_W-1:0]   frame_index;
    logic                fetch_needed;
    logic                writeback_needed;
    logic [TAB_W-1:0]    victim_table;
    logic [PAGE_W-1:0]   victim_page;
    logic [PIN_W-1:0]    pin_after;

    // Shadow copy of the buffer pool.
    logic                bp_valid [NUM_FRAMES];
    logic [TAB_W-1:0]    bp_table [NUM_FRAMES];
    logic [PAGE_W-1:0]   bp_page  [NUM_FRAMES];
    logic [PIN_W-1:0]    bp_pins  [NUM_FRAMES];
    logic                bp_dirty [NUM_FRAMES];
    logic [FIDX_W-1:0]   bp_rank  [NUM_FRAMES];
    int                  bp_filled;
    logic [CFG_W-1:0]    bp_limit;

    page_result_t        expected_results [$];
    int                  mismatch_count;
    int                  cycle_count;
    bit                  idling_on;
    int                  stall_left;

    lru_page_buffer_with_pinning_unit #(
        .NUM_FRAMES(NUM_FRAMES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .table_num        (table_num),
        .page_number      (page_number),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .frame_index      (frame_index),
        .fetch_needed     (fetch_needed),
        .writeback_needed (writeback_needed),
        .victim_table     (victim_table),
        .victim_page      (victim_page),
        .pin_after        (pin_after)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("lru_page_buffer_with_pinning_unit verification failed");
            $finish;
        end
    end

    // Applies one request to the shadow pool and returns the result it causes.
    function automatic bit resolve_request(input page_req_t rq, output page_result_t res);
        int slot;
        int lim;
        logic [FIDX_W-1:0] old_rank;
        res = '0;
        if (rq.kind == REQ_NONE)
            return 1'b0;
        slot = -1;
        for (int i = 0; i < NUM_FRAMES; i++)
            if (slot < 0 && bp_valid[i] && bp_table[i] == rq.tab && bp_page[i] == rq.page)
                slot = i;
        if (rq.kind == REQ_UNPIN)
        begin
            if (slot < 0)
            begin
                res.status = ST_ABSENT;
            end
            else
            begin
                if (bp_pins[slot] != '0)
                    bp_pins[slot]--;
                res.status = ST_HIT;
                res.frame = FIDX_W'(slot);
                res.pin = bp_pins[slot];
            end
            return 1'b1;
        end
        res.status = ST_HIT;
        if (slot < 0)
        begin
            lim = int'(bp_limit);
            if (lim < 1)
                lim = 1;
            if (lim > NUM_FRAMES)
                lim = NUM_FRAMES;
            if (bp_filled < lim)
            begin
                slot = bp_filled;
                bp_filled++;
                res.status = ST_FILL;
            end
            else
            begin
                // Least recently used frame is the one with the highest rank.
                for (int i = 0; i < NUM_FRAMES; i++)
                    if (bp_valid[i] && bp_pins[i] == '0 && (slot < 0 || bp_rank[i] > bp_rank[slot]))
                        slot = i;
                if (slot >= 0)
                begin
                    res.status = ST_REPLACE;
                    res.wb = bp_dirty[slot];
                    res.vtab = bp_table[slot];
                    res.vpage = bp_page[slot];
                end
            end
            if (slot < 0)
            begin
                res.status = ST_PINNED;
                return 1'b1;
            end
            res.fetch = 1'b1;
            bp_valid[slot] = 1'b1;
            bp_table[slot] = rq.tab;
            bp_page[slot] = rq.page;
            bp_pins[slot] = '0;
            bp_dirty[slot] = 1'b0;
        end
        old_rank = bp_rank[slot];
        for (int i = 0; i < NUM_FRAMES; i++)
            if (bp_rank[i] < old_rank)
                bp_rank[i]++;
        bp_rank[slot] = '0;
        if (rq.kind == REQ_READ)
        begin
            if (bp_pins[slot] != PIN_MAX)
                bp_pins[slot]++;
        end
        else
        begin
            if (bp_pins[slot] != '0)
                bp_pins[slot]--;
            bp_dirty[slot] = 1'b1;
        end
        res.frame = FIDX_W'(slot);
        res.pin = bp_pins[slot];
        return 1'b1;
    endfunction

    task automatic send_request(input page_req_t rq);
        page_result_t res;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq.kind;
        table_num <= rq.tab;
        page_number <= rq.page;
        do
            @(posedge clk);
        while (!in_ready);
        if (resolve_request(rq, res))
            expected_results.push_back(res);
    endtask

    // Waits until every result is in and the block has had time to finish
    // any request that produces no result.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        bp_limit = value;
    endtask

    task automatic random_traffic(input int count, input int pool_n, input int pct_read,
                                  input int pct_write, input int pct_unpin);
        logic [TAB_W-1:0]  pool_tab [128];
        logic [PAGE_W-1:0] pool_page [128];
        page_req_t rq;
        int roll;
        int pick;
        for (int k = 0; k < pool_n; k++)
        begin
            roll = $urandom_range(0, 7);
            // Some entries share a table or a page number with their neighbor.
            pool_tab[k] = (k > 0 && roll == 0) ? pool_tab[k-1] : TAB_W'($urandom_range(0, 1023));
            pool_page[k] = (k > 0 && roll == 1) ? pool_page[k-1] : $urandom();
        end
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < pct_read)
                rq.kind = REQ_READ;
            else if (roll < pct_read + pct_write)
                rq.kind = REQ_WRITE;
            else if (roll < pct_read + pct_write + pct_unpin)
                rq.kind = REQ_UNPIN;
            else
                rq.kind = REQ_NONE;
            if ($urandom_range(0, 19) == 0)
            begin
                rq.tab = TAB_W'($urandom_range(0, 1023));
                rq.page = $urandom();
            end
            else
            begin
                pick = $urandom_range(0, pool_n - 1);
                rq.tab = pool_tab[pick];
                rq.page = pool_page[pick];
            end
            send_request(rq);
        end
    endtask

    task automatic test_request_kinds();
        send_request({REQ_READ, 10'h3FF, 32'hFFFF_FFFF});
        send_request({REQ_READ, 10'h000, 32'h0000_0000});
        send_request({REQ_READ, 10'h3FF, 32'hFFFF_FFFF});
        send_request({REQ_WRITE, 10'h3FF, 32'hFFFF_FFFF});
        send_request({REQ_WRITE, 10'h000, 32'h0000_0000});
        send_request({REQ_UNPIN, 10'h000, 32'h0000_0000});
        send_request({REQ_UNPIN, 10'h155, 32'h1234_5678});
        send_request({REQ_WRITE, 10'h000, 32'hFFFF_FFFF});
        send_request({REQ_READ, 10'h3FF, 32'h0000_0000});
        send_request({REQ_NONE, 10'h2AA, 32'hAAAA_5555});
        send_request({REQ_UNPIN, 10'h3FF, 32'hFFFF_FFFF});
    endtask

    // Limit below the filled count: misses replace, then every frame gets
    // pinned so that a miss finds no usable frame; at the end each frame is unpinned once.
    task automatic test_replace_and_pinned();
        write_limit('0);
        send_request({REQ_READ, 10'd100, 32'hA5A5_A5A5});
        send_request({REQ_WRITE, 10'd101, 32'h5A5A_5A5A});
        for (int i = 0; i < NUM_FRAMES; i++)
            if (bp_valid[i] && bp_pins[i] == '0)
                send_request({REQ_READ, bp_table[i], bp_page[i]});
        send_request({REQ_READ, 10'd200, 32'hDEAD_BEEF});
        send_request({REQ_WRITE, 10'd201, 32'hBEEF_DEAD});
        for (int i = 0; i < NUM_FRAMES; i++)
            if (bp_valid[i])
                send_request({REQ_UNPIN, bp_table[i], bp_page[i]});
    endtask

    task automatic test_small_pool();
        write_limit(7'd6);
        random_traffic(150, 10, 45, 25, 25);
    endtask

    task automatic test_full_pool();
        write_limit(7'd127);
        random_traffic(400, 90, 40, 30, 25);
    endtask

    task automatic test_pin_saturation();
        write_limit(CFG_RESET);
        random_traffic(320, 1, 98, 1, 1);
    endtask

    task automatic test_mid_limits();
        write_limit(CFG_W'($urandom_range(1, 126)));
        random_traffic(200, 70, 40, 30, 25);
        write_limit(7'd1);
        random_traffic(150, 80, 35, 35, 25);
    endtask

    task automatic test_back_to_back();
        write_limit(CFG_RESET);
        idling_on = 1'b0;
        random_traffic(300, 80, 40, 30, 25);
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        page_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("status: expected no result, got 0x%0h", status);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("status", want.status, status);
                compare_field("frame_index", want.frame, frame_index);
                compare_field("fetch_needed", want.fetch, fetch_needed);
                compare_field("writeback_needed", want.wb, writeback_needed);
                compare_field("victim_table", want.vtab, victim_table);
                compare_field("victim_page", want.vpage, victim_page);
                compare_field("pin_after", want.pin, pin_after);
            end
        end
    end

    // Result side: random stall bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        req_type <= REQ_NONE;
        table_num <= '0;
        page_number <= '0;
        out_ready <= 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        stall_left = 0;
        idling_on = 1'b1;
        bp_filled = 0;
        bp_limit = CFG_RESET;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            bp_valid[i] = 1'b0;
            bp_table[i] = '0;
            bp_page[i] = '0;
            bp_pins[i] = '0;
            bp_dirty[i] = 1'b0;
            bp_rank[i] = FIDX_W'(i);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_request_kinds();
        test_replace_and_pinned();
        test_small_pool();
        test_full_pool();
        test_pin_saturation();
        test_mid_limits();
        test_back_to_back();

        settle();
        if (mismatch_count == 0)
            $display("lru_page_buffer_with_pinning_unit verification clean");
        else
            $display("lru_page_buffer_with_pinning_unit verification failed");
        $finish;
    end
endmodule
